/* sv/hll_pkg.sv */
// ----------------------------------------------------------------------------
// hll_pkg
// Shared constants for the cardinality sketch.
// ----------------------------------------------------------------------------
`default_nettype none
package hll_pkg;
  localparam int unsigned Precision = 14;
  localparam int unsigned RegCount  = 1 << Precision;
  localparam int unsigned IdxW      = Precision;
  localparam int unsigned CntW      = Precision + 1;
  localparam int unsigned TailRank  = 65 - Precision;

  localparam logic [63:0] AlphaNum = (64'(7213) * 64'(RegCount)) << 32;
  localparam logic [63:0] AlphaDen = 64'(10) * (64'(1000) * 64'(RegCount) + 64'(1079));
  localparam logic [63:0] AlphaQ32 = (64'(2) * AlphaNum + AlphaDen) / (64'(2) * AlphaDen);
  localparam logic [63:0] AlphaM   = AlphaQ32 * 64'(RegCount);
  localparam logic [63:0] AlphaMM  = AlphaM * 64'(RegCount);
  localparam logic [63:0] Ln2Q32   = 64'd2977044472;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_MERGE = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;
endpackage
`default_nettype wire

/* sv/hyperloglog_sketch_unit.sv */
// ----------------------------------------------------------------------------
// hyperloglog_sketch_unit
// HyperLogLog sketch: add, merge and count over one rank memory.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes zero to the 2^14 ranks, one a cycle,
// during which no beat is taken. Add and merge read the rank, compare and
// write it, then present the result and go back to idle once the sink takes
// it. Count walks the memory, one rank a cycle, then runs either a 128-step
// restoring divide or a 128-step divide and a 32-step squaring log loop on
// one shared 32x32 multiplier. One beat is in flight at once.
`default_nettype none
module hyperloglog_sketch_unit import hll_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] mode, [65:2] hash, [79:66] reg_index, [85:80] reg_value, zero pad
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] changed, [64:1] estimate, zero pad
  output logic [71:0]      m_axis_tdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_UPD, S_WALK, S_DECIDE,
    S_DIV, S_LNDIV, S_LOG, S_LNMUL, S_FIN, S_OUT
  } state_e;

  state_e       state_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx_q;
  logic [5:0]   val_q;
  logic [1:0]   mode_q;
  logic [5:0]   rd_q;
  logic [127:0] sum_q;
  logic [CntW-1:0] zeros_q;
  logic [127:0] rem_q, div_a_q, div_b_q;
  logic [63:0]  quo_q;
  logic         over_q;
  logic [7:0]   step_q;
  logic [63:0]  y_q;
  logic [31:0]  frac_q;
  logic [5:0]   k_q;
  logic [63:0]  acc_q;
  logic         changed_q;
  logic [63:0]  est_q;
  logic         lin_q;

  logic [5:0] mem [RegCount];

  // rank of an add: trailing zeros of the tail plus one
  logic [63:0] tail;
  logic [5:0]  rank;
  always_comb begin
    tail = s_axis_tdata[65:2] >> Precision;
    rank = 6'(TailRank);
    for (int i = 63 - Precision; i >= 0; i--) begin
      if (tail[i]) rank = 6'(i + 1);
    end
  end

  logic [5:0]   rc;
  logic [127:0] addend;
  always_comb begin
    rc = (rd_q > 6'd52) ? 6'd52 : rd_q;
    addend = 128'd1 << (52 - rc);
  end

  // largest shift with zeros << k still within the register count
  logic [5:0] k_nx;
  always_comb begin
    k_nx = '0;
    for (int k = 0; k <= Precision; k++) begin
      if ((64'(zeros_q) << k) <= 64'(RegCount)) k_nx = 6'(k);
    end
  end

  // divider step
  logic [127:0] rem_sh;
  logic         rem_ge;
  always_comb begin
    rem_sh = {rem_q[126:0], div_a_q[127]};
    rem_ge = rem_sh >= div_b_q;
  end

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = y_q[31:0];
    mul_b = y_q[31:0];
    if (state_q == S_LNMUL) begin
      mul_a = frac_q;
      mul_b = Ln2Q32[31:0];
    end
    mul_p = mul_a * mul_b;
  end

  logic [63:0] y_nx;
  always_comb y_nx = 64'h1_0000_0000 + {31'd0, y_q[31:0], 1'b0} + {32'd0, mul_p[63:32]};

  logic [127:0] lhs, rhs;
  always_comb begin
    lhs = {64'd0, AlphaM} << 21;
    rhs = (sum_q << 2) + sum_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) mem[cnt_q[IdxW-1:0]] <= '0;
    else if (state_q == S_UPD && val_q > rd_q) mem[idx_q] <= val_q;
    rd_q <= mem[(state_q == S_WALK) ? cnt_q[IdxW-1:0] : idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      changed_q <= 1'b0;
      est_q   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(RegCount - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q <= s_axis_tdata[1:0];
            changed_q <= 1'b0;
            est_q <= '0;
            if (s_axis_tdata[1:0] == MODE_ADD) begin
              idx_q <= s_axis_tdata[2 +: IdxW];
              val_q <= rank;
            end else begin
              idx_q <= IdxW'(s_axis_tdata[79:66]);
              val_q <= s_axis_tdata[85:80];
            end
            cnt_q <= '0;
            sum_q <= '0;
            zeros_q <= '0;
            unique case (s_axis_tdata[1:0])
              MODE_ADD, MODE_MERGE: state_q <= S_RD;
              MODE_COUNT: state_q <= S_WALK;
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_RD: state_q <= S_UPD;
        S_UPD: begin
          changed_q <= val_q > rd_q;
          state_q <= S_OUT;
        end
        S_WALK: begin
          // the read is registered, so the accumulate adds the rank read in the previous cycle
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q != '0) begin
            sum_q <= sum_q + addend;
            if (rd_q == 6'd0) zeros_q <= zeros_q + 1'b1;
          end
          if (cnt_q == CntW'(RegCount)) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          rem_q <= '0;
          quo_q <= '0;
          over_q <= 1'b0;
          step_q <= '0;
          if (zeros_q != '0 && rhs >= lhs) begin
            lin_q <= 1'b1;
            k_q <= k_nx;
            state_q <= S_LNDIV;
          end else begin
            lin_q <= 1'b0;
            div_a_q <= (({64'd0, AlphaMM} << 20) << 1) + sum_q;
            div_b_q <= sum_q << 1;
            state_q <= S_DIV;
          end
        end
        S_LNDIV: begin
          div_a_q <= {64'd0, 64'(RegCount)} << 32;
          div_b_q <= {64'd0, 64'(zeros_q)} << k_q;
          state_q <= S_DIV;
        end
        S_DIV: begin
          div_a_q <= div_a_q << 1;
          if (rem_ge) begin
            rem_q <= rem_sh - div_b_q;
            if (step_q < 8'd64) over_q <= 1'b1;
            else quo_q[~step_q[5:0]] <= 1'b1;
          end else begin
            rem_q <= rem_sh;
          end
          if (step_q == 8'd127) begin
            step_q <= '0;
            state_q <= lin_q ? S_LOG : S_FIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_LOG: begin
          step_q <= step_q + 1'b1;
          if (step_q == '0) begin
            y_q <= quo_q;
            frac_q <= '0;
          end else begin
            if (y_nx >= 64'h2_0000_0000) begin
              y_q <= y_nx >> 1;
              frac_q <= {frac_q[30:0], 1'b1};
            end else begin
              y_q <= y_nx;
              frac_q <= {frac_q[30:0], 1'b0};
            end
          end
          if (step_q == 8'd32) state_q <= S_LNMUL;
        end
        S_LNMUL: begin
          acc_q <= 64'(k_q) * Ln2Q32 + {32'd0, mul_p[63:32]};
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (lin_q) est_q <= ((acc_q << Precision) + 64'h8000_0000) >> 32;
          else est_q <= over_q ? '1 : quo_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) m_axis_tvalid <= 1'b1;
          else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tdata  = {7'd0, est_q, changed_q};

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_est_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mode_q != MODE_COUNT |-> est_q == '0) else $error("estimate leak");
  a_chg_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == MODE_COUNT || mode_q == MODE_NONE) |-> !changed_q)
    else $error("changed on count");
`endif

endmodule
`default_nettype wire
